[rtl/rmq_pkg.sv]
// Package for the rotation matrix to quaternion converter.
// Holds payload structs, widths, branch codes and the output clamp.
// No dependencies.
`timescale 1ns / 1ps

package rmq_pkg;

    localparam int DATA_WIDTH    = 16;
    localparam int FRAC_BITS_DEF = 14;
    localparam int PAIR_W        = DATA_WIDTH + 1;
    localparam int SUM_W         = DATA_WIDTH + 2;
    localparam int QUO_W         = DATA_WIDTH + 1;
    localparam int MID_DEPTH_DEF = 4;
    localparam int OUT_DEPTH_DEF = 2;

    typedef enum logic [1:0] {
        PART_W = 2'd0,
        PART_X = 2'd1,
        PART_Y = 2'd2,
        PART_Z = 2'd3
    } part_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] c0_r0;
        logic signed [DATA_WIDTH-1:0] c0_r1;
        logic signed [DATA_WIDTH-1:0] c0_r2;
        logic signed [DATA_WIDTH-1:0] c1_r0;
        logic signed [DATA_WIDTH-1:0] c1_r1;
        logic signed [DATA_WIDTH-1:0] c1_r2;
        logic signed [DATA_WIDTH-1:0] c2_r0;
        logic signed [DATA_WIDTH-1:0] c2_r1;
        logic signed [DATA_WIDTH-1:0] c2_r2;
    } matrix_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] quat_x;
        logic signed [DATA_WIDTH-1:0] quat_y;
        logic signed [DATA_WIDTH-1:0] quat_z;
        logic signed [DATA_WIDTH-1:0] quat_w;
        part_t                        largest_part;
    } quat_t;

    // Classified request between front and back: the three off-diagonal
    // pairs in output-slot order (skipping the largest slot), the branch,
    // and one plus the largest trace combination.
    typedef struct packed {
        logic signed [PAIR_W-1:0] pa;
        logic signed [PAIR_W-1:0] pb;
        logic signed [PAIR_W-1:0] pc;
        part_t                    part;
        logic [SUM_W-1:0]         s;
    } mid_t;

    function automatic logic signed [DATA_WIDTH-1:0] sat_dw(
        input logic signed [DATA_WIDTH+1:0] v
    );
        logic signed [DATA_WIDTH+1:0] hi;
        logic signed [DATA_WIDTH+1:0] lo;
        hi = (DATA_WIDTH+2)'(2 ** (DATA_WIDTH - 1) - 1);
        lo = -(DATA_WIDTH+2)'(2 ** (DATA_WIDTH - 1));
        if (v > hi)
        begin
            return hi[DATA_WIDTH-1:0];
        end
        else if (v < lo)
        begin
            return lo[DATA_WIDTH-1:0];
        end
        return v[DATA_WIDTH-1:0];
    endfunction

endpackage

[rtl/rotation_matrix_to_quaternion.sv]
// Top level of the rotation matrix to quaternion converter (Shepperd's method).
// Depends on rmq_pkg, rmq_front, rmq_fifo and rmq_back.
//
//   Channel   | Handshake    | Payload
//   ----------+--------------+--------------------------------------------
//   matrix in | push / full  | matrix (rmq_pkg::matrix_t), nine Q1.14 elements
//   quat out  | pop / empty  | quat (rmq_pkg::quat_t), x y z w and branch
//
// One request is accepted every clock cycle while full is low, and one result leaves
// every cycle while pop is high and empty is low. The path runs through two front
// stages, the queue, one stage per root bit, one per quotient bit, and the result queue.
// Reset clears all valid bits and queue pointers; payload registers are not reset.
// A stalled result queue freezes the back end; the front keeps filling the
// middle queue and raises full only once that queue is full and its last stage is taken.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
    parameter int MID_DEPTH = rmq_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH = rmq_pkg::OUT_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  rmq_pkg::matrix_t matrix,
    output logic             empty,
    input  logic             pop,
    output rmq_pkg::quat_t   quat
);

    // Front to queue.
    logic          f_push;
    rmq_pkg::mid_t f_data;
    logic          mid_full;

    // Queue to back.
    logic          mid_empty;
    rmq_pkg::mid_t mid_data;
    logic          mid_pop;

    // Back to result queue.
    logic           res_full;
    logic           res_push;
    rmq_pkg::quat_t res_data;

    // The front forms the four trace combinations and six pairs, then picks
    // the branch and routes the three pairs that need a quotient.
    rmq_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .matrix   (matrix),
        .full     (full),
        .mid_push (f_push),
        .mid_data (f_data),
        .mid_full (mid_full)
    );

    // This queue lets the front keep accepting while the back is held.
    rmq_fifo #(
        .WIDTH ($bits(rmq_pkg::mid_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_push),
        .din   (f_data),
        .full  (mid_full),
        .pop   (mid_pop),
        .dout  (mid_data),
        .empty (mid_empty)
    );

    // The back takes the square root, divides three pairs by four times the
    // largest component with round-to-nearest, and clamps.
    rmq_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_empty (mid_empty),
        .in_data  (mid_data),
        .in_pop   (mid_pop),
        .out_full (res_full),
        .out_push (res_push),
        .out_data (res_data)
    );

    // The result queue separates the consumer from the back pipeline.
    rmq_fifo #(
        .WIDTH ($bits(rmq_pkg::quat_t)),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_data),
        .full  (res_full),
        .pop   (pop),
        .dout  (quat),
        .empty (empty)
    );

endmodule

[rtl/rmq_fifo.sv]
// Small register FIFO used as the front/back queue and the result queue.
// Standalone, no package dependencies.
`timescale 1ns / 1ps

module rmq_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNTW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

endmodule

[rtl/rmq_front.sv]
// Front end: accepts matrices, forms trace combinations and pairs, picks the branch.
// Depends on rmq_pkg.
`timescale 1ns / 1ps

module rmq_front #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rmq_pkg::matrix_t matrix,
    output logic            full,
    output logic            mid_push,
    output rmq_pkg::mid_t   mid_data,
    input  logic            mid_full
);

    localparam int TW = rmq_pkg::SUM_W;
    localparam int PW = rmq_pkg::PAIR_W;

    logic                 f1_vld_reg, f2_vld_reg;
    logic signed [TW-1:0] t0_reg, t1_reg, t2_reg, t3_reg;
    logic signed [TW-1:0] t0_next, t1_next, t2_next, t3_next;
    logic signed [PW-1:0] d12_reg, d20_reg, d01_reg, s01_reg, s20_reg, s12_reg;
    logic signed [PW-1:0] d12_next, d20_next, d01_next, s01_next, s20_next, s12_next;
    rmq_pkg::mid_t        f2_reg, f2_next;
    logic signed [TW-1:0] best;
    logic                 adv;

    assign adv      = !f2_vld_reg || !mid_full;
    assign full     = !adv;
    assign mid_push = f2_vld_reg && !mid_full;
    assign mid_data = f2_reg;

    always_comb
    begin
        t0_next  = TW'(matrix.c0_r0) + TW'(matrix.c1_r1) + TW'(matrix.c2_r2);
        t1_next  = TW'(matrix.c0_r0) - TW'(matrix.c1_r1) - TW'(matrix.c2_r2);
        t2_next  = TW'(matrix.c1_r1) - TW'(matrix.c0_r0) - TW'(matrix.c2_r2);
        t3_next  = TW'(matrix.c2_r2) - TW'(matrix.c0_r0) - TW'(matrix.c1_r1);
        d12_next = PW'(matrix.c1_r2) - PW'(matrix.c2_r1);
        d20_next = PW'(matrix.c2_r0) - PW'(matrix.c0_r2);
        d01_next = PW'(matrix.c0_r1) - PW'(matrix.c1_r0);
        s01_next = PW'(matrix.c0_r1) + PW'(matrix.c1_r0);
        s20_next = PW'(matrix.c2_r0) + PW'(matrix.c0_r2);
        s12_next = PW'(matrix.c1_r2) + PW'(matrix.c2_r1);
    end

    // Ties go to the earliest of w, x, y, z.
    always_comb
    begin
        f2_next = '0;
        if (t0_reg >= t1_reg && t0_reg >= t2_reg && t0_reg >= t3_reg)
        begin
            best         = t0_reg;
            f2_next.part = rmq_pkg::PART_W;
            f2_next.pa   = d12_reg;
            f2_next.pb   = d20_reg;
            f2_next.pc   = d01_reg;
        end
        else if (t1_reg >= t2_reg && t1_reg >= t3_reg)
        begin
            best         = t1_reg;
            f2_next.part = rmq_pkg::PART_X;
            f2_next.pa   = s01_reg;
            f2_next.pb   = s20_reg;
            f2_next.pc   = d12_reg;
        end
        else if (t2_reg >= t3_reg)
        begin
            best         = t2_reg;
            f2_next.part = rmq_pkg::PART_Y;
            f2_next.pa   = s01_reg;
            f2_next.pb   = s12_reg;
            f2_next.pc   = d20_reg;
        end
        else
        begin
            best         = t3_reg;
            f2_next.part = rmq_pkg::PART_Z;
            f2_next.pa   = s20_reg;
            f2_next.pb   = s12_reg;
            f2_next.pc   = d01_reg;
        end
        f2_next.s = TW'(best) + (TW'(1) << FRAC_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            f1_vld_reg <= push;
            f2_vld_reg <= f1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t0_reg  <= t0_next;
            t1_reg  <= t1_next;
            t2_reg  <= t2_next;
            t3_reg  <= t3_next;
            d12_reg <= d12_next;
            d20_reg <= d20_next;
            d01_reg <= d01_next;
            s01_reg <= s01_next;
            s20_reg <= s20_next;
            s12_reg <= s12_next;
            f2_reg  <= f2_next;
        end
    end

endmodule

[rtl/rmq_back.sv]
// Back end: pipelined square root, three pipelined rounding dividers, clamp and placement.
// Depends on rmq_pkg.
`timescale 1ns / 1ps

module rmq_back #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_empty,
    input  rmq_pkg::mid_t   in_data,
    output logic            in_pop,
    input  logic            out_full,
    output logic            out_push,
    output rmq_pkg::quat_t  out_data
);

    localparam int DW   = rmq_pkg::DATA_WIDTH;
    localparam int SW   = rmq_pkg::SUM_W;
    localparam int PW   = rmq_pkg::PAIR_W;
    localparam int QW   = rmq_pkg::QUO_W;
    localparam int RW   = SW + FRAC_BITS;
    localparam int RW2  = RW + (RW % 2);
    localparam int RTW  = RW2 / 2;
    localparam int DENW = RTW + 2;
    localparam int NW   = PW + FRAC_BITS + 1;
    localparam int CW   = (NW > DENW + QW) ? NW : DENW + QW;

    logic adv;

    // Square-root pipeline, one root bit per stage.
    logic            sq_vld_reg  [0:RTW];
    logic [RTW+1:0]  sq_rem_reg  [0:RTW];
    logic [RTW-1:0]  sq_root_reg [0:RTW];
    logic [RW2-1:0]  sq_rad_reg  [0:RTW];
    rmq_pkg::mid_t   sq_meta_reg [0:RTW];

    // Divider pipeline, one quotient bit per stage, three lanes.
    logic                    dv_vld_reg  [0:QW];
    logic [CW-1:0]           dv_r_reg    [0:QW][0:2];
    logic [QW-1:0]           dv_q_reg    [0:QW][0:2];
    logic [2:0]              dv_neg_reg  [0:QW];
    rmq_pkg::part_t          dv_part_reg [0:QW];
    logic signed [DW-1:0]    dv_big_reg  [0:QW];
    logic [CW-1:0]           dv_den_reg  [0:QW];

    assign adv      = !out_full;
    assign in_pop   = adv && !in_empty;
    assign out_push = adv && dv_vld_reg[QW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            sq_vld_reg[0] <= !in_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_rad_reg[0]  <= RW2'(in_data.s) << FRAC_BITS;
            sq_meta_reg[0] <= in_data;
        end
    end

    for (genvar k = 0; k < RTW; k++)
    begin : g_sqrt
        logic [RTW+1:0] rem_sh, trial, rem_next;
        logic [RTW-1:0] root_next;

        always_comb
        begin
            rem_sh = {sq_rem_reg[k][RTW-1:0], sq_rad_reg[k][RW2-1:RW2-2]};
            trial  = {sq_root_reg[k], 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {sq_root_reg[k][RTW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {sq_root_reg[k][RTW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_vld_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                sq_vld_reg[k+1] <= sq_vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_rem_reg[k+1]  <= rem_next;
                sq_root_reg[k+1] <= root_next;
                sq_rad_reg[k+1]  <= sq_rad_reg[k] << 2;
                sq_meta_reg[k+1] <= sq_meta_reg[k];
            end
        end
    end

    // Rounded root, divisor and rounding-biased dividends.
    logic [RTW:0]         root_p1;
    logic [RTW-1:0]       big;
    logic signed [DW-1:0] big_sat;
    logic signed [PW-1:0] lane_p [0:2];
    logic [PW-1:0]        lane_mag [0:2];
    logic [2:0]           lane_neg;

    always_comb
    begin
        root_p1 = (RTW+1)'(sq_root_reg[RTW]) + 1'b1;
        big     = root_p1[RTW:1];
        if (CW'(big) > CW'(2 ** (DW - 1) - 1))
        begin
            big_sat = DW'(2 ** (DW - 1) - 1);
        end
        else
        begin
            big_sat = DW'(big);
        end
        lane_p[0] = sq_meta_reg[RTW].pa;
        lane_p[1] = sq_meta_reg[RTW].pb;
        lane_p[2] = sq_meta_reg[RTW].pc;
        for (int i = 0; i < 3; i++)
        begin
            lane_neg[i] = lane_p[i][PW-1];
            lane_mag[i] = lane_neg[i] ? PW'(-lane_p[i]) : PW'(lane_p[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            dv_vld_reg[0] <= sq_vld_reg[RTW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dv_r_reg[0][i] <= (CW'(lane_mag[i]) << FRAC_BITS) + (CW'(big) << 1);
                dv_q_reg[0][i] <= '0;
            end
            dv_neg_reg[0]  <= lane_neg;
            dv_part_reg[0] <= sq_meta_reg[RTW].part;
            dv_big_reg[0]  <= big_sat;
            dv_den_reg[0]  <= CW'(big) << 2;
        end
    end

    for (genvar j = 0; j < QW; j++)
    begin : g_div
        localparam int SH = QW - 1 - j;
        logic [CW-1:0] dsh;
        logic [CW-1:0] r_next [0:2];
        logic [2:0]    qbit;

        always_comb
        begin
            dsh = dv_den_reg[j] << SH;
            for (int i = 0; i < 3; i++)
            begin
                qbit[i]   = (dv_r_reg[j][i] >= dsh);
                r_next[i] = qbit[i] ? dv_r_reg[j][i] - dsh : dv_r_reg[j][i];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[j+1] <= 1'b0;
            end
            else if (adv)
            begin
                dv_vld_reg[j+1] <= dv_vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    dv_r_reg[j+1][i] <= r_next[i];
                    dv_q_reg[j+1][i] <= {dv_q_reg[j][i][QW-2:0], qbit[i]};
                end
                dv_neg_reg[j+1]  <= dv_neg_reg[j];
                dv_part_reg[j+1] <= dv_part_reg[j];
                dv_big_reg[j+1]  <= dv_big_reg[j];
                dv_den_reg[j+1]  <= dv_den_reg[j];
            end
        end
    end

    // Sign, clamp and place the three quotients around the largest component.
    logic signed [DW+1:0] qs [0:2];
    logic signed [DW-1:0] qc [0:2];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qs[i] = (DW+2)'(dv_q_reg[QW][i]);
            if (dv_neg_reg[QW][i])
            begin
                qs[i] = -qs[i];
            end
            qc[i] = rmq_pkg::sat_dw(qs[i]);
        end
        out_data.largest_part = dv_part_reg[QW];
        unique case (dv_part_reg[QW])
            rmq_pkg::PART_W:
            begin
                out_data.quat_x = qc[0];
                out_data.quat_y = qc[1];
                out_data.quat_z = qc[2];
                out_data.quat_w = dv_big_reg[QW];
            end
            rmq_pkg::PART_X:
            begin
                out_data.quat_x = dv_big_reg[QW];
                out_data.quat_y = qc[0];
                out_data.quat_z = qc[1];
                out_data.quat_w = qc[2];
            end
            rmq_pkg::PART_Y:
            begin
                out_data.quat_x = qc[0];
                out_data.quat_y = dv_big_reg[QW];
                out_data.quat_z = qc[1];
                out_data.quat_w = qc[2];
            end
            default:
            begin
                out_data.quat_x = qc[0];
                out_data.quat_y = qc[1];
                out_data.quat_z = dv_big_reg[QW];
                out_data.quat_w = qc[2];
            end
        endcase
    end

endmodule

[tb/tb.sv]
// Self-checking testbench for rotation_matrix_to_quaternion.
// Drives matrices through the push/full queue port and checks each popped quaternion
// against an in-bench fixed-point predictor. Depends on rmq_pkg and the block RTL.
`timescale 1ns / 1ps

module tb;

    localparam int FB        = rmq_pkg::FRAC_BITS_DEF;
    localparam int LATENCY   = 60;
    localparam int WDOG_MAX  = 4000;
    localparam int N_RANDOM  = 1830;
    localparam logic signed [15:0] ONE = 16'sd16384;

    logic             clk;
    logic             rst_n;
    logic             push;
    logic             full;
    rmq_pkg::matrix_t matrix;
    logic             empty;
    logic             pop;
    rmq_pkg::quat_t   quat;

    // Idle control: when calm is set neither side inserts gaps.
    bit             calm;
    int             fail_count;
    int             wdog;
    rmq_pkg::quat_t expected_quats[$];

    rotation_matrix_to_quaternion u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .matrix (matrix),
        .empty  (empty),
        .pop    (pop),
        .quat   (quat)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Integer square root, floor of the exact root.
    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   -= res + bitv;
                res  = (res >> 1) + bitv;
            end
            else
            begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Off-diagonal pair times 0.25 / big, rounded half away from zero.
    function automatic longint pair_over_big(input longint p, input longint big);
        longint unsigned mag;
        longint unsigned den;
        longint unsigned q;
        mag = (p < 0) ? -p : p;
        den = big * 4;
        q   = ((mag << FB) + den / 2) / den;
        return (p < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    // Predicts the quaternion for one matrix (Shepperd's method, fixed point).
    function automatic rmq_pkg::quat_t predict_quat(input rmq_pkg::matrix_t mx);
        longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
        longint tr[4];
        longint best;
        longint big;
        longint q[4];
        int     idx;
        rmq_pkg::quat_t r;
        m00 = mx.c0_r0; m01 = mx.c0_r1; m02 = mx.c0_r2;
        m10 = mx.c1_r0; m11 = mx.c1_r1; m12 = mx.c1_r2;
        m20 = mx.c2_r0; m21 = mx.c2_r1; m22 = mx.c2_r2;
        tr[0] = m00 + m11 + m22;
        tr[1] = m00 - m11 - m22;
        tr[2] = m11 - m00 - m22;
        tr[3] = m22 - m00 - m11;
        best = tr[0];
        idx  = 0;
        for (int k = 1; k < 4; k++)
        begin
            if (tr[k] > best)
            begin
                best = tr[k];
                idx  = k;
            end
        end
        big = (int_sqrt((best + (64'd1 << FB)) << FB) + 1) >> 1;
        case (idx)
            0:
            begin
                q[0] = pair_over_big(m12 - m21, big);
                q[1] = pair_over_big(m20 - m02, big);
                q[2] = pair_over_big(m01 - m10, big);
                q[3] = big;
            end
            1:
            begin
                q[0] = big;
                q[1] = pair_over_big(m01 + m10, big);
                q[2] = pair_over_big(m20 + m02, big);
                q[3] = pair_over_big(m12 - m21, big);
            end
            2:
            begin
                q[0] = pair_over_big(m01 + m10, big);
                q[1] = big;
                q[2] = pair_over_big(m12 + m21, big);
                q[3] = pair_over_big(m20 - m02, big);
            end
            default:
            begin
                q[0] = pair_over_big(m20 + m02, big);
                q[1] = pair_over_big(m12 + m21, big);
                q[2] = big;
                q[3] = pair_over_big(m01 - m10, big);
            end
        endcase
        r.quat_x       = clamp16(q[0]);
        r.quat_y       = clamp16(q[1]);
        r.quat_z       = clamp16(q[2]);
        r.quat_w       = clamp16(q[3]);
        r.largest_part = rmq_pkg::part_t'(idx);
        return r;
    endfunction

    // Sends one request: optional random idle, then hold push until accepted.
    // push stays high across back-to-back requests, so it is never lowered
    // and raised in the same time step.
    task automatic send_matrix(input rmq_pkg::matrix_t mx);
        while (!calm && $urandom_range(99) < 19)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push   <= 1'b1;
        matrix <= mx;
        @(posedge clk);
        while (full)
            @(posedge clk);
        expected_quats.push_back(predict_quat(mx));
    endtask

    function automatic rmq_pkg::matrix_t random_matrix();
        rmq_pkg::matrix_t mx;
        mx.c0_r0 = 16'($urandom);
        mx.c0_r1 = 16'($urandom);
        mx.c0_r2 = 16'($urandom);
        mx.c1_r0 = 16'($urandom);
        mx.c1_r1 = 16'($urandom);
        mx.c1_r2 = 16'($urandom);
        mx.c2_r0 = 16'($urandom);
        mx.c2_r1 = 16'($urandom);
        mx.c2_r2 = 16'($urandom);
        return mx;
    endfunction

    // One matrix element in Q1.14 with a small random perturbation.
    function automatic logic signed [15:0] to_q14(input real v);
        return 16'($rtoi(v * 16384.0) + int'($urandom_range(4)) - 2);
    endfunction

    // A proper rotation from a random unit quaternion, lightly perturbed, so most
    // requests look like real transforms and spread evenly over the four branches.
    function automatic rmq_pkg::matrix_t rotation_matrix();
        real a, b, c, d, n;
        real e[9];
        rmq_pkg::matrix_t mx;
        a = $urandom_range(2000) - 1000.0;
        b = $urandom_range(2000) - 1000.0;
        c = $urandom_range(2000) - 1000.0;
        d = $urandom_range(2000) - 1000.0;
        n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
        a /= n; b /= n; c /= n; d /= n;
        // Column-major: e[c*3+r].
        e[0] = 1 - 2 * (c * c + d * d); e[1] = 2 * (b * c + a * d); e[2] = 2 * (b * d - a * c);
        e[3] = 2 * (b * c - a * d); e[4] = 1 - 2 * (b * b + d * d); e[5] = 2 * (c * d + a * b);
        e[6] = 2 * (b * d + a * c); e[7] = 2 * (c * d - a * b); e[8] = 1 - 2 * (b * b + c * c);
        mx.c0_r0 = to_q14(e[0]);
        mx.c0_r1 = to_q14(e[1]);
        mx.c0_r2 = to_q14(e[2]);
        mx.c1_r0 = to_q14(e[3]);
        mx.c1_r1 = to_q14(e[4]);
        mx.c1_r2 = to_q14(e[5]);
        mx.c2_r0 = to_q14(e[6]);
        mx.c2_r1 = to_q14(e[7]);
        mx.c2_r2 = to_q14(e[8]);
        return mx;
    endfunction

    // Stops sending and waits until every expected result has come back.
    task automatic drain();
        push <= 1'b0;
        while (expected_quats.size() != 0)
            @(posedge clk);
    endtask

    // Identity, the three half-turns (one per non-w branch), field extremes,
    // and equal trace combinations to exercise the tie order.
    task automatic test_directed();
        rmq_pkg::matrix_t mx;
        mx = '0;
        mx.c0_r0 = ONE; mx.c1_r1 = ONE; mx.c2_r2 = ONE;
        send_matrix(mx);
        mx = '0;
        mx.c0_r0 = ONE; mx.c1_r1 = -ONE; mx.c2_r2 = -ONE;
        send_matrix(mx);
        mx = '0;
        mx.c0_r0 = -ONE; mx.c1_r1 = ONE; mx.c2_r2 = -ONE;
        send_matrix(mx);
        mx = '0;
        mx.c0_r0 = -ONE; mx.c1_r1 = -ONE; mx.c2_r2 = ONE;
        send_matrix(mx);
        // All-zero: every trace combination ties at zero, so w wins.
        send_matrix('0);
        // Diagonals (-a, -a, -a) and (a, a, -a): ties among x, y, z and among w, x, y.
        mx = '0;
        mx.c0_r0 = -ONE; mx.c1_r1 = -ONE; mx.c2_r2 = -ONE;
        send_matrix(mx);
        mx = '0;
        mx.c0_r0 = ONE; mx.c1_r1 = ONE; mx.c2_r2 = -ONE;
        send_matrix(mx);
        // Extremes of every field, which also drive the saturation of the quotients.
        send_matrix({9{16'sh7fff}});
        send_matrix({9{16'sh8000}});
        send_matrix({9{16'hffff}});
        send_matrix({9{16'h0001}});
        mx = {9{16'sh7fff}};
        mx.c0_r0 = 16'sh8000; mx.c1_r1 = 16'sh8000; mx.c2_r2 = 16'sh8000;
        send_matrix(mx);
        mx = {9{16'sh8000}};
        mx.c0_r0 = '0; mx.c1_r1 = '0; mx.c2_r2 = '0;
        mx.c0_r1 = 16'sh7fff; mx.c1_r2 = 16'sh7fff; mx.c2_r0 = 16'sh7fff;
        send_matrix(mx);
        mx = '0;
        mx.c0_r0 = 16'sh8000; mx.c1_r1 = 16'sh8000; mx.c2_r2 = 16'sh7fff;
        mx.c2_r0 = 16'sh7fff; mx.c0_r2 = 16'sh7fff;
        send_matrix(mx);
        mx = '0;
        mx.c0_r0 = 16'sh7fff; mx.c1_r1 = 16'sh8000; mx.c2_r2 = 16'sh8000;
        mx.c0_r1 = 16'sh8000; mx.c1_r0 = 16'sh8000;
        send_matrix(mx);
        drain();
    endtask

    // The sender holds off until every result is back, then resumes.
    task automatic test_pause_until_drained();
        for (int i = 0; i < 8; i++)
            send_matrix(rotation_matrix());
        drain();
        for (int i = 0; i < 8; i++)
            send_matrix(random_matrix());
    endtask

    // Mostly proper rotations, the rest raw bit patterns; one stretch with no idling.
    task automatic test_random();
        for (int i = 0; i < N_RANDOM; i++)
        begin
            calm = (i >= 600 && i < 900);
            if ($urandom_range(99) < 70)
                send_matrix(rotation_matrix());
            else
                send_matrix(random_matrix());
        end
        calm = 1'b0;
    endtask

    // Result side: random stalls on pop, compare each accepted result.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_quats.size() == 0)
                begin
                    $error("unexpected result x=%0d", quat.quat_x);
                    fail_count++;
                end
                else
                begin
                    rmq_pkg::quat_t exp_q;
                    exp_q = expected_quats.pop_front();
                    if (quat.quat_x !== exp_q.quat_x)
                    begin
                        $error("quat_x exp %0d got %0d", exp_q.quat_x, quat.quat_x);
                        fail_count++;
                    end
                    if (quat.quat_y !== exp_q.quat_y)
                    begin
                        $error("quat_y exp %0d got %0d", exp_q.quat_y, quat.quat_y);
                        fail_count++;
                    end
                    if (quat.quat_z !== exp_q.quat_z)
                    begin
                        $error("quat_z exp %0d got %0d", exp_q.quat_z, quat.quat_z);
                        fail_count++;
                    end
                    if (quat.quat_w !== exp_q.quat_w)
                    begin
                        $error("quat_w exp %0d got %0d", exp_q.quat_w, quat.quat_w);
                        fail_count++;
                    end
                    if (quat.largest_part !== exp_q.largest_part)
                    begin
                        $error("largest_part exp %0d got %0d",
                               exp_q.largest_part, quat.largest_part);
                        fail_count++;
                    end
                end
            end
            pop <= calm || ($urandom_range(99) >= 19);
        end
        else
        begin
            pop <= 1'b0;
        end
    end

    // Watchdog: counts cycles in which neither side moves a request.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || !rst_n)
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_MAX)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    initial
    begin
        rst_n  = 1'b0;
        push   = 1'b0;
        matrix = '0;
        calm   = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_pause_until_drained();
        test_random();
        drain();
        repeat (LATENCY) @(posedge clk);
        if (fail_count == 0 && expected_quats.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
